>>> rtl/bpfm_pkg.sv
// Shared constants and types for the buffer pool frame manager.
package bpfm_pkg;

  localparam int unsigned Frames = 4;
  localparam int unsigned FrameW = (Frames > 1) ? $clog2(Frames) : 1;
  localparam int unsigned CountW = $clog2(Frames + 1);
  localparam int unsigned BlockW = 32;
  localparam int unsigned StatusW = 3;

  localparam logic ActAcquire = 1'b0;
  localparam logic ActRelease = 1'b1;

  localparam logic [StatusW-1:0] StHit      = 3'd0;
  localparam logic [StatusW-1:0] StFresh    = 3'd1;
  localparam logic [StatusW-1:0] StEvict    = 3'd2;
  localparam logic [StatusW-1:0] StBusy     = 3'd3;
  localparam logic [StatusW-1:0] StNoSpace  = 3'd4;
  localparam logic [StatusW-1:0] StReleased = 3'd5;
  localparam logic [StatusW-1:0] StRelErr   = 3'd6;

  typedef struct packed {
    logic              vld;
    logic [FrameW-1:0] frm;
  } entry_t;

  typedef struct packed {
    logic found;
    logic take;
    logic prev_vld;
  } chain_t;

endpackage

>>> rtl/bpfm_if.sv
// Request and response channel interfaces of the buffer pool frame manager.
interface bpfm_req_if import bpfm_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              action;
  logic [BlockW-1:0] block_id;
  logic [FrameW-1:0] frame;

  modport source (output valid, output action, output block_id, output frame, input ready);
  modport sink (input valid, input action, input block_id, input frame, output ready);
endinterface

interface bpfm_rsp_if import bpfm_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [StatusW-1:0] status;
  logic [FrameW-1:0]  frame_out;
  logic [BlockW-1:0]  evicted_id;

  modport source (output valid, output status, output frame_out, output evicted_id, input ready);
  modport sink (input valid, input status, input frame_out, input evicted_id, output ready);
endinterface

>>> rtl/buffer_pool_frame_manager.sv
// Buffer pool frame manager: top level with frame table, idle queue chain and response register.
// For each request the frame tags are compared in parallel and the idle queue, a row of slot
// cells that shift toward the head, updates at the edge that loads the response. One request is
// accepted per cycle while the response register is empty or being drained, so the sustained
// rate is one request per clock when the response side keeps ready high.
module buffer_pool_frame_manager import bpfm_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  bpfm_req_if.sink   req_i,
  bpfm_rsp_if.source rsp_o
);

  logic [BlockW-1:0] block_q [Frames];
  logic [Frames-1:0] busy_q;
  logic [CountW-1:0] next_unused_q;

  logic               rsp_valid_q;
  logic [StatusW-1:0] status_q, status_d;
  logic [FrameW-1:0]  frame_out_q, frame_out_d;
  logic [BlockW-1:0]  evicted_q, evicted_d;

  chain_t            ch   [Frames+1];
  entry_t            ent  [Frames+1];
  logic [Frames-1:0] sel;
  logic [Frames-1:0] fm;
  logic [Frames-1:0] used;

  logic              go, acq_go, rel_go;
  logic              hit_any, busy_any, fresh, idle_any, rel_err;
  logic              evict_go;
  logic [FrameW-1:0] hit_frm;
  logic [FrameW-1:0] head_frm;
  logic [FrameW-1:0] nu_frm;

  assign req_i.ready = ~rsp_valid_q | rsp_o.ready;
  assign go          = req_i.valid & req_i.ready;
  assign nu_frm      = next_unused_q[FrameW-1:0];

  always_comb begin
    for (int f = 0; f < Frames; f++) begin
      used[f] = (CountW'(f) < next_unused_q);
      fm[f]   = used[f] & (block_q[f] == req_i.block_id);
    end
  end

  assign hit_any  = ch[Frames].found;
  assign busy_any = |(fm & busy_q);
  assign fresh    = (next_unused_q < CountW'(Frames));
  assign idle_any = ent[0].vld;
  assign head_frm = ent[0].frm;
  assign rel_err  = ~busy_q[req_i.frame] | ent[Frames-1].vld;

  assign acq_go   = go & (req_i.action == ActAcquire);
  assign rel_go   = go & (req_i.action == ActRelease) & ~rel_err;
  assign evict_go = acq_go & ~hit_any & ~busy_any & ~fresh & idle_any;

  assign ch[0].found    = 1'b0;
  assign ch[0].take     = evict_go;
  assign ch[0].prev_vld = 1'b1;
  assign ent[Frames]    = '0;

  for (genvar i = 0; i < Frames; i++) begin : g_cell
    bpfm_qcell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .chain_i     (ch[i]),
      .chain_o     (ch[i+1]),
      .nbr_i       (ent[i+1]),
      .ent_o       (ent[i]),
      .fm_i        (fm),
      .acq_go_i    (acq_go),
      .rel_go_i    (rel_go),
      .rel_frame_i (req_i.frame),
      .sel_o       (sel[i])
    );
  end

  always_comb begin
    hit_frm = '0;
    for (int i = 0; i < Frames; i++) begin
      if (sel[i]) begin
        hit_frm = hit_frm | ent[i].frm;
      end
    end
  end

  always_comb begin
    frame_out_d = '0;
    evicted_d   = '0;
    if (req_i.action == ActRelease) begin
      status_d = rel_err ? StRelErr : StReleased;
    end else begin
      priority if (hit_any) begin
        status_d    = StHit;
        frame_out_d = hit_frm;
      end else if (busy_any) begin
        status_d = StBusy;
      end else if (fresh) begin
        status_d    = StFresh;
        frame_out_d = nu_frm;
      end else if (idle_any) begin
        status_d    = StEvict;
        frame_out_d = head_frm;
        evicted_d   = block_q[head_frm];
      end else begin
        status_d = StNoSpace;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q        <= '0;
      next_unused_q <= '0;
      rsp_valid_q   <= 1'b0;
    end else begin
      if (go) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
      if (rel_go) begin
        busy_q[req_i.frame] <= 1'b0;
      end
      if (acq_go) begin
        priority if (hit_any) begin
          busy_q[hit_frm] <= 1'b1;
        end else if (busy_any) begin
          busy_q <= busy_q;
        end else if (fresh) begin
          busy_q[nu_frm] <= 1'b1;
          next_unused_q  <= next_unused_q + CountW'(1);
        end else if (idle_any) begin
          busy_q[head_frm] <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (go) begin
      status_q    <= status_d;
      frame_out_q <= frame_out_d;
      evicted_q   <= evicted_d;
    end
    if (acq_go & ~hit_any & ~busy_any) begin
      if (fresh) begin
        block_q[nu_frm] <= req_i.block_id;
      end else if (idle_any) begin
        block_q[head_frm] <= req_i.block_id;
      end
    end
  end

  assign rsp_o.valid      = rsp_valid_q;
  assign rsp_o.status     = status_q;
  assign rsp_o.frame_out  = frame_out_q;
  assign rsp_o.evicted_id = evicted_q;

`ifndef SYNTHESIS
  logic [Frames-1:0] idle_busy;
  logic [Frames-1:0] gap;

  always_comb begin
    for (int i = 0; i < Frames; i++) begin
      idle_busy[i] = ent[i].vld & busy_q[ent[i].frm];
      gap[i]       = ent[i+1].vld & ~ent[i].vld;
    end
  end

  a_queue_packed: assert property (@(posedge clk_i) disable iff (!rst_ni) gap == '0)
    else $error("idle queue has a hole");

  a_idle_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni) idle_busy == '0)
    else $error("idle frame marked busy");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    next_unused_q <= CountW'(Frames))
    else $error("unused frame counter out of range");

  a_release_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rel_go |=> !busy_q[$past(req_i.frame)])
    else $error("released frame still busy");

  a_hit_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acq_go && hit_any |-> !busy_q[hit_frm])
    else $error("hit on a busy frame");
`endif

endmodule

>>> rtl/bpfm_qcell.sv
// One slot of the idle queue: holds a frame index and shifts toward the head.
module bpfm_qcell import bpfm_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  chain_t            chain_i,
  output chain_t            chain_o,
  input  entry_t            nbr_i,
  output entry_t            ent_o,
  input  logic [Frames-1:0] fm_i,
  input  logic              acq_go_i,
  input  logic              rel_go_i,
  input  logic [FrameW-1:0] rel_frame_i,
  output logic              sel_o
);

  entry_t ent_q, ent_d;
  logic   match;
  logic   shift;
  logic   append;

  assign match  = ent_q.vld & fm_i[ent_q.frm];
  assign sel_o  = match & ~chain_i.found;
  assign shift  = chain_i.take | (acq_go_i & sel_o);
  assign append = rel_go_i & chain_i.prev_vld & ~ent_q.vld;

  always_comb begin
    ent_d = ent_q;
    if (shift) begin
      ent_d = nbr_i;
    end else if (append) begin
      ent_d.vld = 1'b1;
      ent_d.frm = rel_frame_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ent_q <= '0;
    end else begin
      ent_q <= ent_d;
    end
  end

  assign ent_o            = ent_q;
  assign chain_o.found    = chain_i.found | match;
  assign chain_o.take     = shift;
  assign chain_o.prev_vld = ent_q.vld;

endmodule
